/* sv/fcf_pkg.sv */
// shared constants, codes and control types of the fir convolution filter
package fcf_pkg;

    localparam int TAPS_DEF        = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_BITS        = 64;
    localparam int COEF_IDX_BITS   = 6;
    localparam int FUNC_BITS       = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic init_clr;
        logic hist_push;
        logic hist_zero;
        logic coef_load;
        logic wp_zero;
        logic acc_clr;
        logic issue;
        logic round;
        logic out_load;
    } fcf_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } fcf_sts_t;

endpackage

/* sv/fcf_if.sv */
// valid/ready channel interfaces for commands and filtered results
interface fcf_cmd_if
    import fcf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [FUNC_BITS-1:0]          func;
    logic [COEF_IDX_BITS-1:0]      coef_index;
    logic signed [SAMPLE_BITS-1:0] value;

    modport source (output valid, func, coef_index, value, input ready);
    modport sink (input valid, func, coef_index, value, output ready);
endinterface

interface fcf_result_if
    import fcf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;

    modport source (output valid, filtered, clipped, input ready);
    modport sink (input valid, filtered, clipped, output ready);
endinterface

/* sv/fir_convolution_filter_unit.sv */
// fir convolution filter top level: controller and datapath
//
//   channel  role    carries                              transfer when
//   cmd      sink    func, coef_index, value              cmd.valid & cmd.ready
//   result   source  filtered, clipped (one per push)     result.valid & result.ready
//
// a push runs through the accepting cycle, one multiply-accumulate per tap
// through the shared multiplier, a drain for read and product latency,
// the rounding and the final load
// a coefficient load or an unused code is done in the accepting cycle; a clear then sweeps the delay line to zero
// after reset both stores are zeroed before the first command transfer
// a stalled result waits in the output register; loads and clears still proceed,
// the next push holds before its final load until the register frees
module fir_convolution_filter_unit
    import fcf_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    fcf_cmd_if.sink     cmd,
    fcf_result_if.source result
);

    fcf_cmd_t                cmd_bus;
    fcf_sts_t                sts_bus;
    logic [$clog2(TAPS)-1:0] step;

    fcf_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (cmd.valid),
        .func  (cmd.func),
        .sts   (sts_bus),
        .ready (cmd.ready),
        .cmd   (cmd_bus),
        .step  (step)
    );

    fcf_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_bus),
        .step       (step),
        .coef_index (cmd.coef_index),
        .value      (cmd.value),
        .out_ready  (result.ready),
        .sts        (sts_bus),
        .out_valid  (result.valid),
        .filtered   (result.filtered),
        .clipped    (result.clipped)
    );

endmodule

/* sv/fcf_ram.sv */
// generic single write port ram with registered read
module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/fcf_datapath.sv */
// delay line, coefficient store, multiply-accumulate, rounding and result register
module fcf_datapath
    import fcf_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcf_cmd_t                      cmd,
    input  logic [$clog2(TAPS)-1:0]       step,
    input  logic [COEF_IDX_BITS-1:0]      coef_index,
    input  logic signed [SAMPLE_BITS-1:0] value,
    input  logic                          out_ready,
    output fcf_sts_t                      sts,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          clipped
);

    localparam int AW    = $clog2(TAPS);
    localparam int FRAC  = SAMPLE_BITS - 1;
    localparam int EXT_W = (AW > COEF_IDX_BITS) ? AW : COEF_IDX_BITS;
    localparam logic signed [ACC_BITS-1:0] OUT_MAX = (ACC_BITS'(1) << FRAC) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] OUT_MIN = -(ACC_BITS'(1) << FRAC);
    localparam logic [ACC_BITS-1:0]        HALF    = ACC_BITS'(1) << (FRAC - 1);
    localparam logic [AW-1:0]              LAST    = AW'(TAPS - 1);

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          s1_vld_reg, s2_vld_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic [ACC_BITS-1:0]             acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]      sum_reg;
    logic                            out_vld_reg, out_vld_next;
    logic signed [SAMPLE_BITS-1:0]   filtered_reg;
    logic                            clipped_reg;

    logic                   hist_we, coef_we, idx_ok;
    logic [AW-1:0]          hist_waddr, coef_waddr;
    logic [SAMPLE_BITS-1:0] hist_wdata, coef_wdata;
    logic [SAMPLE_BITS-1:0] hist_rdata, coef_rdata;
    logic [EXT_W-1:0]       idx_ext;
    logic signed [ACC_BITS-1:0] prod_ext;
    logic signed [ACC_BITS-1:0] y;
    logic                   sat_hi, sat_lo;

    assign idx_ext    = EXT_W'(coef_index);
    assign idx_ok     = 32'(coef_index) < 32'(TAPS);

    assign hist_we    = cmd.hist_push | cmd.hist_zero | cmd.init_clr;
    assign hist_waddr = cmd.hist_push ? wp_reg : step;
    assign hist_wdata = cmd.hist_push ? value : '0;

    assign coef_we    = (cmd.coef_load & idx_ok) | cmd.init_clr;
    assign coef_waddr = cmd.init_clr ? step : idx_ext[AW-1:0];
    assign coef_wdata = cmd.init_clr ? '0 : value;

    fcf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (rd_ptr_reg),
        .rdata (hist_rdata)
    );

    fcf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (step),
        .rdata (coef_rdata)
    );

    always_comb
    begin
        wp_next = wp_reg;
        if (cmd.wp_zero)
        begin
            wp_next = '0;
        end
        else if (cmd.hist_push)
        begin
            wp_next = (wp_reg == LAST) ? '0 : wp_reg + AW'(1);
        end

        rd_ptr_next = rd_ptr_reg;
        if (cmd.hist_push)
        begin
            rd_ptr_next = wp_reg;
        end
        else if (cmd.issue)
        begin
            rd_ptr_next = (rd_ptr_reg == '0) ? LAST : rd_ptr_reg - AW'(1);
        end
    end

    assign prod_ext = ACC_BITS'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (s2_vld_reg)
        begin
            acc_next = acc_reg + prod_ext;
        end
    end

    assign y      = sum_reg >>> FRAC;
    assign sat_hi = y > OUT_MAX;
    assign sat_lo = y < OUT_MIN;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rd_ptr_reg  <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rd_ptr_reg  <= rd_ptr_next;
            s1_vld_reg  <= cmd.issue;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= $signed(coef_rdata) * $signed(hist_rdata);
        end
        acc_reg <= acc_next;
        if (cmd.round)
        begin
            sum_reg <= $signed(acc_reg + HALF);
        end
        if (cmd.out_load)
        begin
            filtered_reg <= sat_hi ? OUT_MAX[SAMPLE_BITS-1:0] :
                            sat_lo ? OUT_MIN[SAMPLE_BITS-1:0] : y[SAMPLE_BITS-1:0];
            clipped_reg  <= sat_hi | sat_lo;
        end
    end

    assign sts.pipe_busy = s1_vld_reg | s2_vld_reg;
    assign sts.out_free  = ~out_vld_reg | out_ready;
    assign out_valid     = out_vld_reg;
    assign filtered      = filtered_reg;
    assign clipped       = clipped_reg;

`ifndef SYNTHESIS
    a_acc_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> !s1_vld_reg && !s2_vld_reg)
        else $error("rounding started with products in flight");
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_vld_reg || out_ready)
        else $error("pending result overwritten");
    a_one_hist_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.hist_push, cmd.hist_zero, cmd.init_clr}))
        else $error("conflicting delay line writes");
`endif

endmodule

/* sv/fcf_ctrl.sv */
// sequencer for reset sweep, history clear and the per-tap multiply-accumulate
module fcf_ctrl
    import fcf_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid,
    input  logic [FUNC_BITS-1:0]      func,
    input  fcf_sts_t                  sts,
    output logic                      ready,
    output fcf_cmd_t                  cmd,
    output logic [$clog2(TAPS)-1:0]   step
);

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_CLR   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          last;

    assign last = cnt_reg == LAST;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_clr = 1'b1;
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    case (func)
                        FUNC_LOAD:
                        begin
                            cmd.coef_load = 1'b1;
                        end
                        FUNC_PUSH:
                        begin
                            cmd.hist_push = 1'b1;
                            cmd.acc_clr   = 1'b1;
                            state_next    = S_MAC;
                        end
                        FUNC_CLEAR:
                        begin
                            cmd.wp_zero = 1'b1;
                            state_next  = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                cmd.issue = 1'b1;
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.hist_zero = 1'b1;
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign step = cnt_reg;

`ifndef SYNTHESIS
    a_push_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ready && func == FUNC_PUSH) |=> state_reg == S_MAC && cnt_reg == '0)
        else $error("push did not start the tap sweep at tap zero");
    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DRAIN || state_reg == S_OUT) |-> cnt_reg == '0)
        else $error("tap counter not parked at zero");
    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || cmd.hist_zero || cmd.init_clr) |-> !ready)
        else $error("command taken during a sweep");
`endif

endmodule

/* sim/fir_convolution_filter_unit_checker.sv */
// scoreboard that predicts fir filter outputs from command transfers and compares results
`timescale 1ns / 1ps

module fir_convolution_filter_unit_checker
    import fcf_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    fcf_cmd_if    cmd,
    fcf_result_if result,
    output int    fail_count,
    output int    outstanding
);

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               clipped;
    } fir_out_t;

    localparam logic signed [63:0] OUT_MAX   = 64'sd32767;
    localparam logic signed [63:0] OUT_MIN   = -64'sd32768;
    localparam logic signed [63:0] HALF_LSB  = 64'sd16384;

    logic signed [15:0] delay_line [TAPS_DEF];
    logic signed [15:0] tap_coef [TAPS_DEF];
    logic [5:0]         wr_ptr;
    fir_out_t           expected_out [$];

    function automatic fir_out_t filter_sample(input logic signed [15:0] sample);
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        logic [5:0]         pos;
        fir_out_t           res;
        delay_line[wr_ptr] = sample;
        acc = 64'sd0;
        for (int k = 0; k < TAPS_DEF; k++)
        begin
            pos = wr_ptr - 6'(k);
            acc = acc + tap_coef[k] * delay_line[pos];
        end
        wr_ptr = wr_ptr + 6'd1;
        acc = acc + HALF_LSB;
        scaled = acc >>> 15;
        res.clipped = 1'b0;
        if (scaled > OUT_MAX)
        begin
            scaled = OUT_MAX;
            res.clipped = 1'b1;
        end
        else if (scaled < OUT_MIN)
        begin
            scaled = OUT_MIN;
            res.clipped = 1'b1;
        end
        res.filtered = scaled[15:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fir_out_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS_DEF; k++)
            begin
                delay_line[k] = '0;
                tap_coef[k] = '0;
            end
            wr_ptr = '0;
            expected_out.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transfer filtered %0d clipped %0b",
                             $time, result.filtered, result.clipped);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (result.filtered !== want.filtered || result.clipped !== want.clipped)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected filtered %0d clipped %0b, actual %0d %0b",
                                 $time, want.filtered, want.clipped,
                                 result.filtered, result.clipped);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.func)
                    FUNC_LOAD:
                        tap_coef[cmd.coef_index] = cmd.value;
                    FUNC_PUSH:
                    begin
                        want = filter_sample(cmd.value);
                        expected_out = {expected_out, want};
                    end
                    FUNC_CLEAR:
                    begin
                        for (int k = 0; k < TAPS_DEF; k++)
                            delay_line[k] = '0;
                        wr_ptr = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            outstanding = expected_out.size();
        end
    end

endmodule

/* sim/fir_convolution_filter_unit_tb.sv */
// stimulus and verdict for the fir convolution filter unit
`timescale 1ns / 1ps

module fir_convolution_filter_unit_tb;
    import fcf_pkg::*;

    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [15:0]   S_MAX = 16'sh7fff;
    localparam logic signed [15:0]   S_MIN = 16'sh8000;
    localparam int                   RANDOM_ITEMS = 450;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;

    fcf_cmd_if    cmd_ch ();
    fcf_result_if res_ch ();

    fir_convolution_filter_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    fir_convolution_filter_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .result      (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [15:0] pick_coef();
        logic signed [15:0] mag;
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3: return 16'($urandom);
            default:
            begin
                mag = 16'($urandom_range(0, 2047));
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [FUNC_BITS-1:0] f,
                             input logic [COEF_IDX_BITS-1:0] idx,
                             input logic signed [15:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= f;
        cmd_ch.coef_index <= idx;
        cmd_ch.value <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // result sink backpressure
    initial
    begin
        int r;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else if (r < 92)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 100)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int r;
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= FUNC_LOAD;
        cmd_ch.coef_index <= '0;
        cmd_ch.value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale negative squared clips positive
        send_item(FUNC_LOAD, 6'd0, S_MIN);
        send_item(FUNC_PUSH, 6'd17, S_MIN);
        send_item(FUNC_PUSH, 6'd0, S_MAX);
        send_item(FUNC_LOAD, 6'd63, S_MAX);
        send_item(FUNC_LOAD, 6'd1, S_MAX);
        send_item(FUNC_PUSH, 6'd42, S_MAX);
        send_item(FUNC_PUSH, 6'd63, S_MAX);
        send_item(FUNC_CLEAR, 6'd63, S_MIN);
        send_item(FUNC_UNUSED, 6'd63, -16'sd1);
        // negative saturation across two taps
        send_item(FUNC_LOAD, 6'd0, S_MAX);
        send_item(FUNC_PUSH, 6'd5, S_MIN);
        send_item(FUNC_PUSH, 6'd5, S_MIN);
        send_item(FUNC_CLEAR, 6'd0, 16'sd0);
        send_item(FUNC_LOAD, 6'd1, 16'sd0);
        send_item(FUNC_LOAD, 6'd63, 16'sd0);
        // rounding at exactly half an lsb
        send_item(FUNC_LOAD, 6'd0, 16'sd1);
        send_item(FUNC_PUSH, 6'd0, 16'sd16384);
        send_item(FUNC_PUSH, 6'd0, -16'sd16384);
        send_item(FUNC_PUSH, 6'd0, 16'sd16383);
        send_item(FUNC_CLEAR, 6'd21, 16'sd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                send_item(FUNC_LOAD, 6'($urandom_range(0, 63)), pick_coef());
            else if (r < 90)
                send_item(FUNC_PUSH, 6'($urandom), pick_sample());
            else if (r < 95)
                send_item(FUNC_CLEAR, 6'($urandom), 16'($urandom));
            else
                send_item(FUNC_UNUSED, 6'($urandom), 16'($urandom));
        end
        cmd_ch.valid <= 1'b0;
        @(posedge clk);

        wait (outstanding == 0);
        repeat (TAPS_DEF + 20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
